// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/slec_pkg.sv =====
// ----------------------------------------------------------------------------
// slec_pkg
// Types, constants and microcode ROM for the console line editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slec_pkg;

   localparam int LINE_CAPACITY = 32;
   localparam int LEN_W         = $clog2(LINE_CAPACITY);
   localparam int PC_W          = 6;

   localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(LINE_CAPACITY - 1);
   localparam logic [LEN_W-1:0] CMP_SPAN    = LEN_W'(8);
   localparam logic [LEN_W-1:0] RESET_LEN   = LEN_W'(5);
   localparam logic [LEN_W-1:0] DDRTEST_LEN = LEN_W'(7);

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   localparam logic [1:0] CMD_NONE     = 2'd0;
   localparam logic [1:0] CMD_ID_RESET = 2'd1;
   localparam logic [1:0] CMD_DDRTEST  = 2'd2;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_CONST,
      EMIT_BYTE,
      EMIT_MEM,
      EMIT_CMD
   } emit_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_CLR_LEN,
      ACT_MINIT,
      ACT_CLR_IDX,
      ACT_READ,
      ACT_CMP
   } act_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_EMPTY,
      J_MATCH,
      J_MORE,
      J_MORE_CMP,
      J_END
   } jmp_type;

   typedef struct packed {
      emit_type         emit;
      logic [7:0]       ch;
      logic             last;
      act_type          act;
      jmp_type          jmp;
      logic [PC_W-1:0]  target;
   } uword_type;

   // Entry points
   localparam logic [PC_W-1:0] P_PROMPT  = 6'd0;
   localparam logic [PC_W-1:0] P_ECHO    = 6'd2;
   localparam logic [PC_W-1:0] P_BS      = 6'd3;
   localparam logic [PC_W-1:0] P_FF      = 6'd6;
   localparam logic [PC_W-1:0] P_EOL     = 6'd7;
   localparam logic [PC_W-1:0] P_CMPLOOP = 6'd10;
   localparam logic [PC_W-1:0] P_ECHOLN  = 6'd31;
   localparam logic [PC_W-1:0] P_CMD     = 6'd37;

   function automatic uword_type ucw(emit_type e, logic [7:0] c, logic l,
                                     act_type a, jmp_type j, logic [PC_W-1:0] t);
      uword_type w;
      w.emit   = e;
      w.ch     = c;
      w.last   = l;
      w.act    = a;
      w.jmp    = j;
      w.target = t;
      return w;
   endfunction

   function automatic uword_type ucode_rom(logic [PC_W-1:0] pc);
      uword_type w;
      w = ucw(EMIT_NONE, 8'h00, 1'b0, ACT_NONE, J_END, P_PROMPT);
      case (pc)
         // prompt
         6'd0:  w = ucw(EMIT_CONST, CH_GT,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd1:  w = ucw(EMIT_CONST, CH_SPACE, 1'b1, ACT_CLR_LEN, J_END,  P_PROMPT);
         // printable echo
         6'd2:  w = ucw(EMIT_BYTE,  8'h00,    1'b1, ACT_NONE,    J_END,  P_PROMPT);
         // rubout
         6'd3:  w = ucw(EMIT_CONST, CH_BS,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd4:  w = ucw(EMIT_CONST, CH_SPACE, 1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd5:  w = ucw(EMIT_CONST, CH_BS,    1'b1, ACT_NONE,    J_END,  P_PROMPT);
         // form feed
         6'd6:  w = ucw(EMIT_CONST, CH_FF,    1'b0, ACT_NONE,    J_GOTO, P_PROMPT);
         // end of line
         6'd7:  w = ucw(EMIT_CONST, CH_CR,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd8:  w = ucw(EMIT_CONST, CH_LF,    1'b0, ACT_NONE,    J_EMPTY, P_PROMPT);
         6'd9:  w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_MINIT,   J_NEXT, P_PROMPT);
         6'd10: w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_READ,    J_NEXT, P_PROMPT);
         6'd11: w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_CMP,     J_MORE_CMP, P_CMPLOOP);
         6'd12: w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_NONE,    J_MATCH, P_CMD);
         // "Unknown command '"
         6'd13: w = ucw(EMIT_CONST, 8'h55,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd14: w = ucw(EMIT_CONST, 8'h6E,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd15: w = ucw(EMIT_CONST, 8'h6B,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd16: w = ucw(EMIT_CONST, 8'h6E,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd17: w = ucw(EMIT_CONST, 8'h6F,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd18: w = ucw(EMIT_CONST, 8'h77,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd19: w = ucw(EMIT_CONST, 8'h6E,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd20: w = ucw(EMIT_CONST, CH_SPACE, 1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd21: w = ucw(EMIT_CONST, 8'h63,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd22: w = ucw(EMIT_CONST, 8'h6F,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd23: w = ucw(EMIT_CONST, 8'h6D,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd24: w = ucw(EMIT_CONST, 8'h6D,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd25: w = ucw(EMIT_CONST, 8'h61,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd26: w = ucw(EMIT_CONST, 8'h6E,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd27: w = ucw(EMIT_CONST, 8'h64,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd28: w = ucw(EMIT_CONST, CH_SPACE, 1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd29: w = ucw(EMIT_CONST, CH_QUOTE, 1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         // line contents, closing quote, dot and CR LF
         6'd30: w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_CLR_IDX, J_NEXT, P_PROMPT);
         6'd31: w = ucw(EMIT_NONE,  8'h00,    1'b0, ACT_READ,    J_NEXT, P_PROMPT);
         6'd32: w = ucw(EMIT_MEM,   8'h00,    1'b0, ACT_NONE,    J_MORE, P_ECHOLN);
         6'd33: w = ucw(EMIT_CONST, CH_QUOTE, 1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd34: w = ucw(EMIT_CONST, CH_DOT,   1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd35: w = ucw(EMIT_CONST, CH_CR,    1'b0, ACT_NONE,    J_NEXT, P_PROMPT);
         6'd36: w = ucw(EMIT_CONST, CH_LF,    1'b0, ACT_NONE,    J_GOTO, P_PROMPT);
         // command pulse
         6'd37: w = ucw(EMIT_CMD,   8'h00,    1'b0, ACT_NONE,    J_GOTO, P_PROMPT);
         default: w = ucw(EMIT_NONE, 8'h00,   1'b0, ACT_NONE,    J_END,  P_PROMPT);
      endcase
      return w;
   endfunction

   function automatic logic [7:0] reset_char(logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0:    c = 8'h72;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h73;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ddrtest_char(logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0:    c = 8'h64;
         3'd1:    c = 8'h64;
         3'd2:    c = 8'h72;
         3'd3:    c = 8'h74;
         3'd4:    c = 8'h65;
         3'd5:    c = 8'h73;
         3'd6:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/slec_linebuf.sv =====
// ----------------------------------------------------------------------------
// slec_linebuf
// Line buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slec_linebuf (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [slec_pkg::LEN_W-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic                      rd_en,
   input  wire logic [slec_pkg::LEN_W-1:0] rd_addr,
   output      logic [7:0]                rd_data
);
   import slec_pkg::*;

   logic [7:0] line_mem_ff [LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/serial_line_editor_command_match.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor_command_match
// Console line editor with exact command matching, run by a microcode ROM.
// ----------------------------------------------------------------------------
// The first result is written into the output register by the sequencer's
// first step; each further step of the microcode program advances while the
// output is not stalled by rsp_valid held with rsp_ready low. An item occupies
// the sequencer for its emitting steps plus its non-emitting steps.
// A new request is taken once the program reaches its final step.
// Reset: synchronous; line length cleared, buffer contents left undefined.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor_command_match (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_interrupt_event,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_tx_byte,
   output      logic       rsp_tx_valid,
   output      logic [1:0] rsp_command_id,
   output      logic       rsp_last_result
);
   import slec_pkg::*;

   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [2:0]       rd_idx_ff, rd_idx_in;
   logic [7:0]       byte_ff, byte_in;
   logic             match_r_ff, match_r_in;
   logic             match_d_ff, match_d_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_txv_ff, out_txv_in;
   logic [1:0]       out_cmd_ff, out_cmd_in;
   logic             out_last_ff, out_last_in;

   uword_type        uw;
   logic             stall, fire, accept;
   logic             is_print, is_rubout;
   logic             wr_en, rd_en;
   logic [7:0]       rd_data;
   logic [PC_W-1:0]  pc_next;

   assign uw        = ucode_rom(pc_ff);
   assign stall     = (uw.emit != EMIT_NONE) && out_valid_ff && !rsp_ready;
   assign fire      = busy_ff && !stall;
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;

   assign is_print  = (req_rx_byte >= CH_SPACE) && (req_rx_byte <= CH_TILDE);
   assign is_rubout = (req_rx_byte == CH_BS) || (req_rx_byte == CH_DEL);
   assign wr_en     = accept && !req_interrupt_event && is_print && (len_ff != LEN_MAX);
   assign rd_en     = fire && (uw.act == ACT_READ);
   assign pc_next   = pc_ff + PC_W'(1);

   slec_linebuf u_linebuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // sequencer, dispatch and datapath
   always_comb begin
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      rd_idx_in  = rd_idx_ff;
      byte_in    = byte_ff;
      match_r_in = match_r_ff;
      match_d_in = match_d_ff;

      if (accept) begin
         byte_in = req_rx_byte;
         if (req_interrupt_event) begin
            busy_in = 1'b1;
            pc_in   = P_PROMPT;
         end else if ((req_rx_byte == CH_CR) || (req_rx_byte == CH_LF)) begin
            busy_in = 1'b1;
            pc_in   = P_EOL;
         end else if (is_rubout) begin
            if (len_ff != '0) begin
               len_in  = len_ff - LEN_W'(1);
               busy_in = 1'b1;
               pc_in   = P_BS;
            end
         end else if (is_print) begin
            if (len_ff != LEN_MAX) begin
               len_in  = len_ff + LEN_W'(1);
               busy_in = 1'b1;
               pc_in   = P_ECHO;
            end
         end else if (req_rx_byte == CH_FF) begin
            busy_in = 1'b1;
            pc_in   = P_FF;
         end
      end

      if (fire) begin
         case (uw.act)
            ACT_CLR_LEN: len_in = '0;
            ACT_MINIT: begin
               idx_in     = '0;
               match_r_in = (len_ff == RESET_LEN);
               match_d_in = (len_ff == DDRTEST_LEN);
            end
            ACT_CLR_IDX: idx_in = '0;
            ACT_READ: begin
               idx_in    = idx_ff + LEN_W'(1);
               rd_idx_in = idx_ff[2:0];
            end
            ACT_CMP: begin
               match_r_in = match_r_ff && (rd_data == reset_char(rd_idx_ff));
               match_d_in = match_d_ff && (rd_data == ddrtest_char(rd_idx_ff));
            end
            default: ;
         endcase

         case (uw.jmp)
            J_NEXT:     pc_in = pc_next;
            J_GOTO:     pc_in = uw.target;
            J_EMPTY:    pc_in = (len_ff == '0) ? uw.target : pc_next;
            J_MATCH:    pc_in = (match_r_ff || match_d_ff) ? uw.target : pc_next;
            J_MORE:     pc_in = (idx_ff < len_ff) ? uw.target : pc_next;
            J_MORE_CMP: pc_in = ((idx_ff < len_ff) && (idx_ff < CMP_SPAN)) ?
                                uw.target : pc_next;
            J_END:      busy_in = 1'b0;
            default:    busy_in = 1'b0;
         endcase
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_txv_in   = out_txv_ff;
      out_cmd_in   = out_cmd_ff;
      out_last_in  = out_last_ff;
      if (fire && (uw.emit != EMIT_NONE)) begin
         out_valid_in = 1'b1;
         out_last_in  = uw.last;
         out_txv_in   = 1'b1;
         out_cmd_in   = CMD_NONE;
         case (uw.emit)
            EMIT_CONST: out_byte_in = uw.ch;
            EMIT_BYTE:  out_byte_in = byte_ff;
            EMIT_MEM:   out_byte_in = rd_data;
            EMIT_CMD: begin
               out_byte_in = 8'h00;
               out_txv_in  = 1'b0;
               out_cmd_in  = match_r_ff ? CMD_ID_RESET : CMD_DDRTEST;
            end
            default:    out_byte_in = uw.ch;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
      pc_ff       <= pc_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      byte_ff     <= byte_in;
      match_r_ff  <= match_r_in;
      match_d_ff  <= match_d_in;
      out_byte_ff <= out_byte_in;
      out_txv_ff  <= out_txv_in;
      out_cmd_ff  <= out_cmd_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tx_byte     = out_byte_ff;
   assign rsp_tx_valid    = out_txv_ff;
   assign rsp_command_id  = out_cmd_ff;
   assign rsp_last_result = out_last_ff;

endmodule

`default_nettype wire

// ===== src/slec_checker.sv =====
// ----------------------------------------------------------------------------
// slec_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slec_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_tx_valid,
   input wire logic [1:0] rsp_command_id,
   input wire logic       rsp_last_result
);
   import slec_pkg::*;

   logic        rsp_stall;
   logic        rsp_cmd;
   logic [11:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_cmd     = rsp_valid && (rsp_command_id != CMD_NONE);
   assign rsp_payload = {rsp_tx_byte, rsp_tx_valid, rsp_command_id, rsp_last_result};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload), "stall")
   `ASSERT_IMPLY(a_cmd_shape, clock, reset, rsp_cmd, {rsp_tx_valid, rsp_last_result, rsp_tx_byte} == '0, "cmd")
   `ASSERT_IMPLY(a_notx_is_cmd, clock, reset, rsp_valid && !rsp_tx_valid, rsp_cmd, "no tx")
   `ASSERT_NEXT(a_cmd_prompt, clock, reset, rsp_cmd && rsp_ready, rsp_valid && (rsp_tx_byte == CH_GT), "prompt")
   `ASSERT_IMPLY(a_busy_mid, clock, reset, rsp_valid && !rsp_last_result, !req_ready, "mid-sequence")

endmodule

bind serial_line_editor_command_match slec_checker u_slec_checker (.*);

`default_nettype wire
